[hw/rtl/pas_pkg.sv]
`default_nettype none

package pas_pkg;

  localparam int unsigned DATA_W = 8;
  localparam int unsigned LEN_W = 12;
  localparam int unsigned POS_W = 13;
  localparam int unsigned MAX_W = 13;
  localparam int unsigned CRC_W = 32;
  localparam int unsigned PADDR_W = 2;
  localparam int unsigned PDATA_W = 32;

  localparam logic [CRC_W-1:0] CRC_POLY = 32'h04C1_1DB7;
  localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;
  localparam logic [MAX_W-1:0] MAX_SECTION_RESET = 13'd1024;

  // header layout: byte positions within the section
  localparam logic [POS_W-1:0] POS_LEN_HI = 13'd1;
  localparam logic [POS_W-1:0] POS_LEN_LO = 13'd2;
  localparam logic [POS_W-1:0] POS_TSID_HI = 13'd3;
  localparam logic [POS_W-1:0] POS_TSID_LO = 13'd4;
  localparam logic [POS_W-1:0] POS_VERSION = 13'd5;
  localparam logic [POS_W-1:0] POS_SECTION = 13'd6;
  localparam logic [POS_W-1:0] POS_LAST = 13'd7;
  localparam logic [POS_W-1:0] POS_FIRST_ENTRY = 13'd8;

  localparam int unsigned HDR_BYTES = 3;
  localparam int unsigned CRC_TAIL = 2;
  localparam logic [LEN_W-1:0] MIN_BODY_LEN = 12'd9;

  localparam logic [PADDR_W-1:0] REG_MAX_SECTION = 2'd0;

  typedef enum logic [1:0] {
    STATUS_OK     = 2'd0,
    STATUS_CRC    = 2'd1,
    STATUS_LENGTH = 2'd2,
    STATUS_EMPTY  = 2'd3
  } status_t;

  typedef enum logic {
    KIND_ENTRY = 1'b0,
    KIND_END   = 1'b1
  } kind_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       section_start;
  } req_t;

  typedef struct packed {
    kind_t       kind;
    logic [15:0] program_number;
    logic [12:0] program_pid;
    logic [15:0] stream_id;
    logic [4:0]  version;
    logic        current_ind;
    logic [7:0]  section_index;
    logic [7:0]  last_section_index;
    status_t     status;
  } rsp_t;

  typedef struct packed {
    logic valid;
    req_t data;
  } stage_t;

  typedef struct packed {
    logic valid;
    rsp_t data;
  } result_t;

endpackage

`default_nettype wire

[hw/rtl/pas_cfg.sv]
`default_nettype none

module pas_cfg (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [pas_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [pas_pkg::PDATA_W-1:0]  pwdata,
  output logic      [pas_pkg::PDATA_W-1:0]  prdata,
  output logic                              pready,
  output logic      [pas_pkg::MAX_W-1:0]    max_section_bytes
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en = psel && penable && pwrite && (paddr == pas_pkg::REG_MAX_SECTION);

  always_ff @(posedge clk) begin
    if (rst) begin
      max_section_bytes <= pas_pkg::MAX_SECTION_RESET;
    end else if (wr_en) begin
      max_section_bytes <= pwdata[pas_pkg::MAX_W-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (paddr == pas_pkg::REG_MAX_SECTION) begin
      prdata = {{(pas_pkg::PDATA_W - pas_pkg::MAX_W){1'b0}}, max_section_bytes};
    end
  end

endmodule

`default_nettype wire

[hw/rtl/pas_in_reg.sv]
`default_nettype none

module pas_in_reg (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire pas_pkg::req_t req_data,
  input  wire logic          hold,
  output pas_pkg::stage_t    stage
);

  assign req_stall = stage.valid && hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (!req_stall) begin
      stage.valid <= req_valid;
    end
    if (req_valid && !req_stall) begin
      stage.data <= req_data;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/pas_core.sv]
`default_nettype none

module pas_core (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire pas_pkg::stage_t            stage,
  input  wire logic                       hold,
  input  wire logic [pas_pkg::MAX_W-1:0]  max_section_bytes,
  output pas_pkg::result_t                result
);

  logic                           active;
  logic [pas_pkg::POS_W-1:0]      pos;
  logic [pas_pkg::LEN_W-1:0]      body_len;
  logic [pas_pkg::CRC_W-1:0]      crc;
  logic [15:0]                    tsid;
  logic [4:0]                     version;
  logic                           cur_next;
  logic [7:0]                     sec_idx;
  logic [7:0]                     last_idx;
  logic [23:0]                    entry;

  logic                           active_next;
  logic [pas_pkg::POS_W-1:0]      pos_next;
  logic [pas_pkg::LEN_W-1:0]      body_len_next;
  logic [pas_pkg::CRC_W-1:0]      crc_next;
  logic [15:0]                    tsid_next;
  logic [4:0]                     version_next;
  logic                           cur_next_next;
  logic [7:0]                     sec_idx_next;
  logic [7:0]                     last_idx_next;
  logic [23:0]                    entry_next;

  logic                           live;
  logic                           update;
  logic [pas_pkg::POS_W-1:0]      cur_pos;
  logic [7:0]                     b;
  logic                           in_entries;
  logic                           at_end;
  logic [pas_pkg::POS_W:0]        pos_plus_tail;
  logic [pas_pkg::POS_W-1:0]      end_pos;
  logic [pas_pkg::MAX_W-1:0]      total_len;
  pas_pkg::status_t               status;

  function automatic logic [pas_pkg::CRC_W-1:0] crc_byte(
    input logic [pas_pkg::CRC_W-1:0] c_in,
    input logic [7:0]                d
  );
    logic [pas_pkg::CRC_W-1:0] c;
    c = c_in ^ {d, 24'h0};
    for (int k = 0; k < 8; k++) begin
      c = c[pas_pkg::CRC_W-1] ? ((c << 1) ^ pas_pkg::CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

  assign b = stage.data.data_byte;
  assign live = stage.valid && (stage.data.section_start || active);
  assign update = live && !hold;

  always_comb begin
    // a flagged byte restarts the section from clean state
    if (stage.data.section_start) begin
      cur_pos       = '0;
      body_len_next = '0;
      crc_next      = pas_pkg::CRC_INIT;
      tsid_next     = '0;
      version_next  = '0;
      cur_next_next = 1'b0;
      sec_idx_next  = '0;
      last_idx_next = '0;
      entry_next    = '0;
    end else begin
      cur_pos       = pos;
      body_len_next = body_len;
      crc_next      = crc;
      tsid_next     = tsid;
      version_next  = version;
      cur_next_next = cur_next;
      sec_idx_next  = sec_idx;
      last_idx_next = last_idx;
      entry_next    = entry;
    end

    crc_next = crc_byte(crc_next, b);
    pos_next = cur_pos + pas_pkg::POS_W'(1);

    unique case (cur_pos)
      pas_pkg::POS_LEN_HI:  body_len_next = {b[3:0], 8'h00};
      pas_pkg::POS_LEN_LO:  body_len_next = {body_len_next[11:8], b};
      pas_pkg::POS_TSID_HI: tsid_next = {b, 8'h00};
      pas_pkg::POS_TSID_LO: tsid_next = {tsid_next[15:8], b};
      pas_pkg::POS_VERSION: begin
        version_next  = b[5:1];
        cur_next_next = b[0];
      end
      pas_pkg::POS_SECTION: sec_idx_next = b;
      pas_pkg::POS_LAST:    last_idx_next = b;
      default: ;
    endcase

    pos_plus_tail = {1'b0, cur_pos} + (pas_pkg::POS_W + 1)'(pas_pkg::CRC_TAIL);
    end_pos = {1'b0, body_len_next} + pas_pkg::POS_W'(pas_pkg::CRC_TAIL);
    in_entries = (cur_pos >= pas_pkg::POS_FIRST_ENTRY) &&
                 (pos_plus_tail <= {2'b00, body_len_next});
    at_end = (cur_pos >= pas_pkg::POS_LEN_LO) && (cur_pos == end_pos);

    total_len = {1'b0, body_len_next} + pas_pkg::MAX_W'(pas_pkg::HDR_BYTES);
    priority if (crc_next != '0) begin
      status = pas_pkg::STATUS_CRC;
    end else if ((total_len > max_section_bytes) ||
                 (body_len_next < pas_pkg::MIN_BODY_LEN) ||
                 (body_len_next[1:0] != 2'b01)) begin
      status = pas_pkg::STATUS_LENGTH;
    end else if (body_len_next == pas_pkg::MIN_BODY_LEN) begin
      status = pas_pkg::STATUS_EMPTY;
    end else begin
      status = pas_pkg::STATUS_OK;
    end

    result.valid = 1'b0;
    result.data  = '0;
    active_next  = 1'b1;

    if (in_entries) begin
      if (cur_pos[1:0] != 2'b11) begin
        entry_next = {entry_next[15:0], b};
      end else begin
        result.valid               = update;
        result.data.kind           = pas_pkg::KIND_ENTRY;
        result.data.program_number = entry_next[23:8];
        result.data.program_pid    = {entry_next[4:0], b};
      end
    end

    if (at_end) begin
      result.valid                   = update;
      result.data.kind               = pas_pkg::KIND_END;
      result.data.stream_id          = tsid_next;
      result.data.version            = version_next;
      result.data.current_ind        = cur_next_next;
      result.data.section_index      = sec_idx_next;
      result.data.last_section_index = last_idx_next;
      result.data.status             = status;
      active_next                    = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (update) begin
      active <= active_next;
    end
  end

  always_ff @(posedge clk) begin
    if (update) begin
      pos      <= pos_next;
      body_len <= body_len_next;
      crc      <= crc_next;
      tsid     <= tsid_next;
      version  <= version_next;
      cur_next <= cur_next_next;
      sec_idx  <= sec_idx_next;
      last_idx <= last_idx_next;
      entry    <= entry_next;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/pas_out_reg.sv]
`default_nettype none

module pas_out_reg (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire pas_pkg::result_t result,
  input  wire logic             rsp_stall,
  output logic                  rsp_valid,
  output pas_pkg::rsp_t         rsp_data,
  output logic                  hold
);

  // full and not being taken
  assign hold = rsp_valid && rsp_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (result.valid) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (result.valid) begin
      rsp_data <= result.data;
    end
  end

endmodule

`default_nettype wire

[hw/rtl/pat_section_parser.sv]
// path: an accepted request sits in the input register; the output register then takes the result it completes
// throughput: one byte per cycle while not stalled, through the combinational crc and field update path
// a full output register that is stalled holds the input register, which then stalls
// reset: synchronous, active high; drops any open section, empties both registers
// and returns max_section_bytes to 1024
`default_nettype none

module pat_section_parser (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [pas_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [pas_pkg::PDATA_W-1:0]  pwdata,
  output logic      [pas_pkg::PDATA_W-1:0]  prdata,
  output logic                              pready,
  input  wire logic                         req_valid,
  output logic                              req_stall,
  input  wire pas_pkg::req_t                req_data,
  output logic                              rsp_valid,
  input  wire logic                         rsp_stall,
  output pas_pkg::rsp_t                     rsp_data
);

  logic [pas_pkg::MAX_W-1:0] max_section_bytes;
  logic                      hold;
  pas_pkg::stage_t           stage;
  pas_pkg::result_t          result;

  pas_cfg u_cfg (
    .clk               (clk),
    .rst               (rst),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready),
    .max_section_bytes (max_section_bytes)
  );

  pas_in_reg u_in_reg (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_data  (req_data),
    .hold      (hold),
    .stage     (stage)
  );

  pas_core u_core (
    .clk               (clk),
    .rst               (rst),
    .stage             (stage),
    .hold              (hold),
    .max_section_bytes (max_section_bytes),
    .result            (result)
  );

  pas_out_reg u_out_reg (
    .clk       (clk),
    .rst       (rst),
    .result    (result),
    .rsp_stall (rsp_stall),
    .rsp_valid (rsp_valid),
    .rsp_data  (rsp_data),
    .hold      (hold)
  );

endmodule

`default_nettype wire

[hw/rtl/pas_checker.sv]
`default_nettype none

module pas_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          req_stall,
  input wire logic          rsp_valid,
  input wire logic          rsp_stall,
  input wire pas_pkg::rsp_t rsp_data
);

  // input side only backs up behind a stalled result
  a_stall_cause: assert property (@(posedge clk)
    req_stall |-> (rsp_valid && rsp_stall))
    else $error("request stalled without a held result");

  a_reset_empty: assert property (@(posedge clk)
    rst |=> !rsp_valid)
    else $error("result valid after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
    else $error("stalled result changed");

  a_entry_clean: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp_data.kind == pas_pkg::KIND_ENTRY)) |->
      ((rsp_data.stream_id == '0) && (rsp_data.version == '0) &&
       (rsp_data.current_ind == 1'b0) && (rsp_data.section_index == '0) &&
       (rsp_data.last_section_index == '0) && (rsp_data.status == pas_pkg::STATUS_OK)))
    else $error("entry result carries header fields");

  a_end_clean: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (rsp_data.kind == pas_pkg::KIND_END)) |->
      ((rsp_data.program_number == '0) && (rsp_data.program_pid == '0)))
    else $error("end result carries entry fields");

endmodule

bind pat_section_parser pas_checker u_pas_checker (
  .clk       (clk),
  .rst       (rst),
  .req_stall (req_stall),
  .rsp_valid (rsp_valid),
  .rsp_stall (rsp_stall),
  .rsp_data  (rsp_data)
);

`default_nettype wire

[tb/tb.sv]
`default_nettype none

module tb;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES = 48;
  localparam int TARGET_BYTES = 1600;
  localparam int SETTLE_CYCLES = 4;

  class pat_scoreboard;
    logic [12:0] max_bytes;
    int pos;
    logic [11:0] body_len;
    logic [31:0] crc;
    logic [15:0] tsid;
    logic [4:0] ver;
    logic cur_next;
    logic [7:0] sec_num;
    logic [7:0] last_num;
    logic [23:0] entry;
    bit active;
    pas_pkg::rsp_t expected_q[$];
    int errors;
    int entries;
    int ends;
    int status_count[4];

    function new();
      max_bytes = pas_pkg::MAX_SECTION_RESET;
      active = 0;
      errors = 0;
      entries = 0;
      ends = 0;
      foreach (status_count[i]) status_count[i] = 0;
      clear_section();
    endfunction

    static function logic [31:0] crc_next(logic [31:0] c, logic [7:0] b);
      c ^= {b, 24'h0};
      for (int k = 0; k < 8; k++) c = c[31] ? ((c << 1) ^ pas_pkg::CRC_POLY) : (c << 1);
      return c;
    endfunction

    function void clear_section();
      pos = 0;
      body_len = '0;
      crc = pas_pkg::CRC_INIT;
      tsid = '0;
      ver = '0;
      cur_next = 1'b0;
      sec_num = '0;
      last_num = '0;
      entry = '0;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // returns 1 when the byte is parsed, 0 when it is ignored
    function bit note_request(pas_pkg::req_t r);
      int p;
      int len;
      pas_pkg::rsp_t e;
      if (r.section_start) begin
        clear_section();
        active = 1;
      end else if (!active) begin
        return 0;
      end
      crc = crc_next(crc, r.data_byte);
      p = pos;
      pos++;
      case (p)
        1: body_len = {r.data_byte[3:0], 8'h00};
        2: body_len[7:0] = r.data_byte;
        3: tsid[15:8] = r.data_byte;
        4: tsid[7:0] = r.data_byte;
        5: begin
          ver = r.data_byte[5:1];
          cur_next = r.data_byte[0];
        end
        6: sec_num = r.data_byte;
        7: last_num = r.data_byte;
        default: ;
      endcase
      len = int'(body_len);
      if (p >= 8 && p + 2 <= len) begin
        if ((p - 8) % 4 < 3) begin
          entry = {entry[15:0], r.data_byte};
        end else begin
          e = '0;
          e.kind = pas_pkg::KIND_ENTRY;
          e.program_number = entry[23:8];
          e.program_pid = {entry[4:0], r.data_byte};
          expected_q.push_back(e);
        end
      end
      if (p >= 2 && p == len + 2) begin
        e = '0;
        e.kind = pas_pkg::KIND_END;
        e.stream_id = tsid;
        e.version = ver;
        e.current_ind = cur_next;
        e.section_index = sec_num;
        e.last_section_index = last_num;
        if (crc != 0)
          e.status = pas_pkg::STATUS_CRC;
        else if (len + 3 > int'(max_bytes) || len < 9 || (len - 9) % 4 != 0)
          e.status = pas_pkg::STATUS_LENGTH;
        else if (len == 9)
          e.status = pas_pkg::STATUS_EMPTY;
        else
          e.status = pas_pkg::STATUS_OK;
        expected_q.push_back(e);
        active = 0;
      end
      return 1;
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("mismatch: %s", msg);
    endtask

    task compare_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want) report($sformatf("%s got %h want %h", name, got, want));
    endtask

    task check_result(pas_pkg::rsp_t got);
      pas_pkg::rsp_t want;
      if (expected_q.size() == 0) begin
        report($sformatf("result with nothing expected, kind %0d", got.kind));
        return;
      end
      want = expected_q.pop_front();
      compare_field("kind", 16'(got.kind), 16'(want.kind));
      compare_field("program_number", got.program_number, want.program_number);
      compare_field("program_pid", 16'(got.program_pid), 16'(want.program_pid));
      compare_field("stream_id", got.stream_id, want.stream_id);
      compare_field("version", 16'(got.version), 16'(want.version));
      compare_field("current_ind", 16'(got.current_ind), 16'(want.current_ind));
      compare_field("section_index", 16'(got.section_index), 16'(want.section_index));
      compare_field("last_section_index", 16'(got.last_section_index),
                    16'(want.last_section_index));
      compare_field("status", 16'(got.status), 16'(want.status));
      if (want.kind == pas_pkg::KIND_ENTRY) begin
        entries++;
      end else begin
        ends++;
        status_count[want.status]++;
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [pas_pkg::PADDR_W-1:0] paddr = '0;
  logic [pas_pkg::PDATA_W-1:0] pwdata = '0;
  logic [pas_pkg::PDATA_W-1:0] prdata;
  logic pready;
  logic req_valid = 1'b0;
  logic req_stall;
  pas_pkg::req_t req_data = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  pas_pkg::rsp_t rsp_data;

  int gap_pct = 16;
  bit hold_rsp = 0;
  int parsed_bytes = 0;
  int quiet_cycles = 0;
  logic [7:0] sec_bytes[$];
  pat_scoreboard sb = new();

  pat_section_parser DUT (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_data(req_data),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp_data(rsp_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_rsp) begin
        rsp_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_rsp = 0;
      end
      rsp_stall <= ($urandom_range(99) < gap_pct);
    end
  end

  always @(negedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) sb.check_result(rsp_data);
  end

  always @(negedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic s);
    pas_pkg::req_t r;
    r.data_byte = b;
    r.section_start = s;
    while ($urandom_range(99) < gap_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req_data <= r;
    do @(negedge clk); while (req_stall);
    if (sb.note_request(r)) parsed_bytes++;
    @(posedge clk);
  endtask

  task automatic send_section(input int count);
    for (int i = 0; i < count && i < sec_bytes.size(); i++)
      send_byte(sec_bytes[i], i == 0);
  endtask

  // last four bytes become the crc, so a sealed section leaves a zero residue
  function automatic void seal_crc();
    logic [31:0] c;
    int n;
    n = sec_bytes.size();
    if (n < 7) return;
    c = pas_pkg::CRC_INIT;
    for (int i = 0; i < n - 4; i++) c = pat_scoreboard::crc_next(c, sec_bytes[i]);
    sec_bytes[n-4] = c[31:24];
    sec_bytes[n-3] = c[23:16];
    sec_bytes[n-2] = c[15:8];
    sec_bytes[n-1] = c[7:0];
  endfunction

  function automatic void make_section(input int body);
    sec_bytes.delete();
    sec_bytes.push_back(($urandom_range(3) == 0) ? 8'($urandom) : 8'h00);
    sec_bytes.push_back({4'($urandom), 4'(body >> 8)});
    sec_bytes.push_back(8'(body));
    while (sec_bytes.size() < 3 + body) sec_bytes.push_back(8'($urandom));
    seal_crc();
  endfunction

  task automatic write_max_bytes(input logic [12:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= pas_pkg::REG_MAX_SECTION;
    pwdata <= pas_pkg::PDATA_W'(value);
    @(posedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!pready);
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.max_bytes = value;
  endtask

  task automatic settle();
    req_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic random_burst();
    int r;
    int n;
    int idx;
    r = $urandom_range(99);
    n = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(6);
    if (r < 60) begin
      make_section(9 + 4 * n);
      send_section(sec_bytes.size());
    end else if (r < 70) begin
      make_section(9 + 4 * n);
      idx = $urandom_range(sec_bytes.size() - 1, 3);
      sec_bytes[idx] ^= 8'(1 << $urandom_range(7));
      send_section(sec_bytes.size());
    end else if (r < 78) begin
      make_section($urandom_range(48));
      send_section(sec_bytes.size());
    end else if (r < 86) begin
      make_section(9 + 4 * n);
      send_section($urandom_range(sec_bytes.size() - 1, 1));
    end else if (r < 93) begin
      make_section($urandom_range(4095));
      send_section($urandom_range(20, 2));
    end else begin
      repeat ($urandom_range(5, 1)) send_byte(8'($urandom), 1'b0);
    end
  endtask

  initial begin
    int short_bodies[4] = '{0, 1, 5, 8};
    int phase_max[6] = '{12, 4096, 1024, 0, 13, 64};
    int m;
    int b;
    int mark;

    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // stray bytes before any section start
    repeat (3) send_byte(8'($urandom), 1'b0);

    // header all ones with a zero entry and a ones entry, then header and entry all zeros
    make_section(9 + 4 * 2);
    for (int i = 3; i < 8; i++) sec_bytes[i] = 8'hFF;
    for (int i = 8; i < 12; i++) sec_bytes[i] = 8'h00;
    for (int i = 12; i < 16; i++) sec_bytes[i] = 8'hFF;
    seal_crc();
    send_section(sec_bytes.size());
    make_section(9 + 4);
    for (int i = 3; i < 12; i++) sec_bytes[i] = 8'h00;
    seal_crc();
    send_section(sec_bytes.size());

    // no entries, then corrupted crc
    make_section(9);
    send_section(sec_bytes.size());
    make_section(21);
    sec_bytes[10] ^= 8'h10;
    send_section(sec_bytes.size());

    // short sections end early
    foreach (short_bodies[i]) begin
      make_section(short_bodies[i]);
      send_section(sec_bytes.size());
    end

    // partial trailing entry
    make_section(11);
    send_section(sec_bytes.size());
    make_section(10);
    send_section(sec_bytes.size());

    // restart inside an open section
    make_section(25);
    send_section(12);
    make_section(13);
    send_section(sec_bytes.size());

    settle();

    // output held off while input keeps coming
    hold_rsp = 1;
    make_section(9 + 4 * 20);
    send_section(sec_bytes.size());
    repeat (2) send_byte(8'($urandom), 1'b0);

    foreach (phase_max[k]) begin
      settle();
      m = (phase_max[k] == 0) ? $urandom_range(4096, 12) : phase_max[k];
      write_max_bytes(13'(m));
      gap_pct = (k == 2) ? 0 : 16;
      if (m <= 80) begin
        b = 9 + 4 * ((m - 12) / 4);
        make_section(b);
        send_section(sec_bytes.size());
        if (b + 4 <= 4095) begin
          make_section(b + 4);
          send_section(sec_bytes.size());
        end
      end
      mark = parsed_bytes;
      while (parsed_bytes - mark < TARGET_BYTES / 12) random_burst();
      make_section(13);
      send_section(sec_bytes.size());
    end

    settle();
    repeat (8) @(posedge clk);
    $display("run covered %0d parsed bytes, %0d program entries and %0d section ends",
             parsed_bytes, sb.entries, sb.ends);
    $display("end status seen: ok %0d, crc %0d, length %0d, no entries %0d",
             sb.status_count[0], sb.status_count[1], sb.status_count[2],
             sb.status_count[3]);
    if (sb.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

`default_nettype wire
